@@ design/sorted_table_search_engine_macros.svh @@
`ifndef SORTED_TABLE_SEARCH_ENGINE_MACROS_SVH
`define SORTED_TABLE_SEARCH_ENGINE_MACROS_SVH

// concurrent property check, sampled on clk, off during reset
`define STSE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// follow-on check: post must hold in the cycle after pre
`define STSE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) pre |=> post) else $error(msg);

`endif

@@ design/stse_pkg.sv @@
package stse_pkg;

	localparam int WORD_BITS = 32;
	localparam int DEPTH_DEF = 128;
	localparam int PW        = 11;
	localparam int FIB_LEN   = 15;

	localparam logic [2:0] MODE_SEQ  = 3'd0;
	localparam logic [2:0] MODE_BACK = 3'd1;
	localparam logic [2:0] MODE_BIN  = 3'd2;
	localparam logic [2:0] MODE_INT  = 3'd3;
	localparam logic [2:0] MODE_FIB  = 3'd4;

	localparam logic REG_MODE  = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	localparam logic ACT_WRITE  = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic                        action;
		logic [7:0]                  position;
		logic signed [WORD_BITS-1:0] word;
	} in_item_t;

	typedef struct packed {
		logic       result_kind;
		logic [7:0] found_position;
	} out_item_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_WRITE, OP_START, OP_SEQ, OP_HIT_TAG, OP_BIN_PROBE, OP_NARROW,
		OP_HIT_MID, OP_FIB_K, OP_FIB_PROBE, OP_RD_LOW, OP_RD_HIGH, OP_INT_SETUP,
		OP_MUL, OP_HALVE, OP_DIV_INIT, OP_DIV_STEP, OP_INT_MID, OP_RD_MID, OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		logic n_zero;
		logic lh_ok;
		logic eq;
		logic seq_hit;
		logic seq_end;
		logic fib_k_done;
		logic k_pos;
		logic int_out;
		logic int_simple;
		logic ovf;
		logic den_zero;
		logic div_last;
		logic out_full;
	} ctl_sts_t;

	function automatic logic [PW-1:0] fib_val(input logic [3:0] idx);
		logic [PW-1:0] v;
		unique case (idx)
			4'd0:  v = PW'(0);
			4'd1:  v = PW'(1);
			4'd2:  v = PW'(1);
			4'd3:  v = PW'(2);
			4'd4:  v = PW'(3);
			4'd5:  v = PW'(5);
			4'd6:  v = PW'(8);
			4'd7:  v = PW'(13);
			4'd8:  v = PW'(21);
			4'd9:  v = PW'(34);
			4'd10: v = PW'(55);
			4'd11: v = PW'(89);
			4'd12: v = PW'(144);
			4'd13: v = PW'(233);
			4'd14: v = PW'(377);
			default: v = PW'(0);
		endcase
		return v;
	endfunction

endpackage

@@ design/stse_dp.sv @@
`include "sorted_table_search_engine_macros.svh"

module stse_dp #(
	parameter int DEPTH = stse_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  stse_pkg::ctl_cmd_t  cmd,
	output stse_pkg::ctl_sts_t  sts,
	input  stse_pkg::in_item_t  in_data,
	input  logic [2:0]          mode,
	input  logic [7:0]          count,
	input  logic                out_ready,
	output logic                out_valid,
	output stse_pkg::out_item_t out_data
);
	import stse_pkg::*;

	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PRW = WORD_BITS + PW;
	localparam int QW  = $clog2(PW);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rd_q, key_q, lo_v_q, num_q, den_q;
	logic [PRW-1:0]       prod_q, rem_q;
	logic [PW-1:0]        low_q, high_q, mid_q, n_q, tag_s1, quo_q;
	logic [QW-1:0]        qi_q;
	logic signed [5:0]    k_q;
	logic                 kind_q, seqv_s1, out_valid_q;
	logic [7:0]           res_q;
	out_item_t            out_q;

	logic [WORD_BITS-1:0] key_in;
	logic [PW-1:0]        n_in, bmid, fmid, fclamp, span, seq_end_pos, msum, rd_pos;
	logic [PRW-1:0]       den_sh;
	logic [PRW:0]         trial;
	logic                 rd_en, back, wr_ok;

	assign key_in = {~in_data.word[WORD_BITS-1], in_data.word[WORD_BITS-2:0]};
	assign n_in   = (32'(count) > DEPTH) ? PW'(DEPTH) : PW'(count);
	assign back   = (mode == MODE_BACK);
	assign wr_ok  = (in_data.position != 8'd0) && (32'(in_data.position) <= DEPTH);
	assign bmid   = PW'(({1'b0, low_q} + {1'b0, high_q}) >> 1);
	assign fmid   = low_q + fib_val(4'(k_q - 6'sd1)) - PW'(1);
	assign fclamp = (fmid > n_q) ? n_q : fmid;
	assign span   = high_q - low_q;
	assign seq_end_pos = back ? PW'(1) : n_q;
	assign msum   = low_q + quo_q;
	assign den_sh = PRW'(den_q) << qi_q;
	assign trial  = {1'b0, rem_q} - {1'b0, den_sh};

	always_comb begin
		rd_en  = 1'b1;
		rd_pos = mid_q;
		unique case (cmd.op)
			OP_SEQ, OP_RD_MID: rd_pos = mid_q;
			OP_BIN_PROBE:      rd_pos = bmid;
			OP_FIB_PROBE:      rd_pos = fclamp;
			OP_RD_LOW:         rd_pos = low_q;
			OP_RD_HIGH:        rd_pos = high_q;
			default:           rd_en  = 1'b0;
		endcase
	end

	always_comb begin
		sts.n_zero     = (n_in == '0);
		sts.lh_ok      = (low_q <= high_q);
		sts.eq         = (rd_q == key_q);
		sts.seq_hit    = seqv_s1 && (rd_q == key_q);
		sts.seq_end    = seqv_s1 && (tag_s1 == seq_end_pos);
		sts.fib_k_done = !((k_q < 6'(FIB_LEN - 1)) && (fib_val(k_q[3:0]) <= n_q));
		sts.k_pos      = (k_q > 6'sd0);
		sts.int_out    = (key_q < lo_v_q) || (key_q > rd_q);
		sts.int_simple = (rd_q == lo_v_q) || (high_q == low_q);
		sts.ovf        = ((prod_q >> 64) != '0);
		sts.den_zero   = (den_q == '0);
		sts.div_last   = (qi_q == '0);
		sts.out_full   = out_valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			seqv_s1     <= 1'b0;
		end else begin
			if (cmd.op == OP_OUT)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cmd.op == OP_START)
				seqv_s1 <= 1'b0;
			else if (cmd.op == OP_SEQ)
				seqv_s1 <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_WRITE && wr_ok)
			mem[AW'(in_data.position - 8'd1)] <= key_in;
		if (rd_en)
			rd_q <= mem[AW'(rd_pos - PW'(1))];
		unique case (cmd.op)
			OP_WRITE: begin
				kind_q <= 1'b0;
				res_q  <= 8'd0;
			end
			OP_START: begin
				kind_q <= 1'b1;
				res_q  <= 8'd0;
				key_q  <= key_in;
				n_q    <= n_in;
				low_q  <= PW'(1);
				high_q <= n_in;
				k_q    <= 6'sd0;
				mid_q  <= back ? n_in : PW'(1);
			end
			OP_SEQ: begin
				tag_s1 <= mid_q;
				if (mid_q != seq_end_pos)
					mid_q <= back ? mid_q - PW'(1) : mid_q + PW'(1);
			end
			OP_HIT_TAG:   res_q <= 8'(tag_s1);
			OP_BIN_PROBE: mid_q <= bmid;
			OP_NARROW: begin
				if (key_q < rd_q) begin
					high_q <= mid_q - PW'(1);
					k_q    <= k_q - 6'sd1;
				end else begin
					low_q <= mid_q + PW'(1);
					k_q   <= k_q - 6'sd2;
				end
			end
			OP_HIT_MID:   res_q <= 8'((mid_q > n_q) ? n_q : mid_q);
			OP_FIB_K:     k_q <= k_q + 6'sd1;
			OP_FIB_PROBE: mid_q <= fmid;
			OP_RD_HIGH:   lo_v_q <= rd_q;
			OP_INT_SETUP: begin
				num_q <= key_q - lo_v_q;
				den_q <= rd_q - lo_v_q;
				mid_q <= low_q;
			end
			OP_MUL:   prod_q <= PRW'(span) * PRW'(num_q);
			OP_HALVE: begin
				num_q <= num_q >> 1;
				den_q <= den_q >> 1;
			end
			OP_DIV_INIT: begin
				rem_q <= prod_q;
				quo_q <= '0;
				qi_q  <= QW'(PW - 1);
			end
			OP_DIV_STEP: begin
				if (!trial[PRW]) begin
					rem_q       <= trial[PRW-1:0];
					quo_q[qi_q] <= 1'b1;
				end
				qi_q <= qi_q - QW'(1);
			end
			OP_INT_MID: mid_q <= (msum > high_q) ? high_q : msum;
			OP_OUT: begin
				out_q.result_kind    <= kind_q;
				out_q.found_position <= res_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	`STSE_ASSERT(a_hit_mid_nonzero, (cmd.op == OP_HIT_MID) |-> (mid_q != '0), "hit at position zero")
	`STSE_ASSERT_NEXT(a_hit_tag_result, (cmd.op == OP_HIT_TAG), (res_q != 8'd0), "scan hit lost")
	`STSE_ASSERT_NEXT(a_out_hold, (out_valid_q && !out_ready), out_valid_q, "result dropped")

endmodule

@@ design/stse_ctrl.sv @@
`include "sorted_table_search_engine_macros.svh"

module stse_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_action,
	output logic               in_ready,
	input  logic               out_ready,
	input  logic [2:0]         mode,
	input  stse_pkg::ctl_sts_t sts,
	output stse_pkg::ctl_cmd_t cmd
);
	import stse_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_FIN, S_SEQ, S_BPROBE, S_CMP, S_FK, S_FPROBE, S_ILOW, S_IHIGH,
		S_ICHK, S_IMUL, S_IOVF, S_IDIV, S_IMID, S_IPROBE
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NOP;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (in_action == ACT_WRITE) begin
						cmd.op  = OP_WRITE;
						state_d = S_FIN;
					end else begin
						cmd.op = OP_START;
						if (sts.n_zero)
							state_d = S_FIN;
						else begin
							unique case (mode)
								MODE_SEQ, MODE_BACK: state_d = S_SEQ;
								MODE_BIN:            state_d = S_BPROBE;
								MODE_INT:            state_d = S_ILOW;
								MODE_FIB:            state_d = S_FK;
								default:             state_d = S_FIN;
							endcase
						end
					end
				end
			end
			S_SEQ: begin
				priority if (sts.seq_hit) begin
					cmd.op  = OP_HIT_TAG;
					state_d = S_FIN;
				end else if (sts.seq_end)
					state_d = S_FIN;
				else
					cmd.op = OP_SEQ;
			end
			S_BPROBE: begin
				if (!sts.lh_ok)
					state_d = S_FIN;
				else begin
					cmd.op  = OP_BIN_PROBE;
					state_d = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.eq) begin
					cmd.op  = OP_HIT_MID;
					state_d = S_FIN;
				end else begin
					cmd.op = OP_NARROW;
					unique case (mode)
						MODE_INT: state_d = S_ILOW;
						MODE_FIB: state_d = S_FPROBE;
						default:  state_d = S_BPROBE;
					endcase
				end
			end
			S_FK: begin
				if (sts.fib_k_done)
					state_d = S_FPROBE;
				else
					cmd.op = OP_FIB_K;
			end
			S_FPROBE: begin
				if (!(sts.lh_ok && sts.k_pos))
					state_d = S_FIN;
				else begin
					cmd.op  = OP_FIB_PROBE;
					state_d = S_CMP;
				end
			end
			S_ILOW: begin
				if (!sts.lh_ok)
					state_d = S_FIN;
				else begin
					cmd.op  = OP_RD_LOW;
					state_d = S_IHIGH;
				end
			end
			S_IHIGH: begin
				cmd.op  = OP_RD_HIGH;
				state_d = S_ICHK;
			end
			S_ICHK: begin
				cmd.op = OP_INT_SETUP;
				priority if (sts.int_out)
					state_d = S_FIN;
				else if (sts.int_simple)
					state_d = S_IPROBE;
				else
					state_d = S_IMUL;
			end
			S_IMUL: begin
				cmd.op  = OP_MUL;
				state_d = S_IOVF;
			end
			S_IOVF: begin
				priority if (sts.ovf) begin
					cmd.op  = OP_HALVE;
					state_d = S_IMUL;
				end else if (sts.den_zero)
					state_d = S_IPROBE;
				else begin
					cmd.op  = OP_DIV_INIT;
					state_d = S_IDIV;
				end
			end
			S_IDIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last)
					state_d = S_IMID;
			end
			S_IMID: begin
				cmd.op  = OP_INT_MID;
				state_d = S_IPROBE;
			end
			S_IPROBE: begin
				cmd.op  = OP_RD_MID;
				state_d = S_CMP;
			end
			S_FIN: begin
				if (!sts.out_full || out_ready) begin
					cmd.op  = OP_OUT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	`STSE_ASSERT_NEXT(a_busy_after_take, (in_valid && in_ready), !in_ready, "took a second item")
	`STSE_ASSERT(a_out_slot_free, (cmd.op == OP_OUT) |-> (!sts.out_full || out_ready), "result overrun")
	`STSE_ASSERT_NEXT(a_div_ends, (state_q == S_IDIV && sts.div_last), (state_q == S_IMID), "divide did not end")

endmodule

@@ design/sorted_table_search_engine.sv @@
// Sorted table search engine: one item at a time. A write transfer, like a search, can
// stall on the output. Searches: forward/backward scans read the entries in turn; binary
// search reads one entry per probe; Fibonacci search first picks its index, then probes;
// interpolation search per probe does two end reads and, unless the case is simple, a
// multiply, overflow halving as needed and an 11-step divider. The speed is set by the
// single-port table memory, which gives one registered read per cycle, and by the
// bit-serial divider.
module sorted_table_search_engine #(
	parameter int DEPTH = stse_pkg::DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  stse_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output stse_pkg::out_item_t out_data,
	input  logic                cfg_write,
	input  logic                cfg_index,
	input  logic [7:0]          cfg_data
);
	import stse_pkg::*;

	logic [2:0] mode_q;
	logic [7:0] count_q;
	ctl_cmd_t   cmd;
	ctl_sts_t   sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BIN;
			count_q <= 8'd1;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_MODE:  mode_q  <= cfg_data[2:0];
				REG_COUNT: count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	stse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.mode      (mode_q),
		.sts       (sts),
		.cmd       (cmd)
	);

	stse_dp #(.DEPTH(DEPTH)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_data   (in_data),
		.mode      (mode_q),
		.count     (count_q),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
